// File: rtl/tcp_segment_reorder_buffer_macros.svh
// Assertion helpers for the reorder buffer.
`ifndef TCP_SEGMENT_REORDER_BUFFER_MACROS_SVH
`define TCP_SEGMENT_REORDER_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
`define TSRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TSRB_ASSERT(lbl, prop, msg)
`define TSRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/tsrb_pkg.sv
`timescale 1ns / 1ps

package tsrb_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] seq_number;
        logic [15:0] payload_length;
        logic [15:0] buffer_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_seq;
        logic [15:0] out_length;
        logic [15:0] out_handle;
        logic [31:0] next_expected;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic [15:0] handle;
    } seg_t;

    // Broadcast to every cell for the current transfer
    typedef struct packed {
        logic ins_shift;
        logic ins_replace;
        logic pop;
        seg_t seg;
    } cell_ctl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

// File: rtl/tsrb_cell.sv
`timescale 1ns / 1ps

module tsrb_cell
    import tsrb_pkg::*;
(
    input  logic             clk,
    input  logic [CNT_W-1:0] idx,
    input  logic [CNT_W-1:0] count,
    input  cell_ctl_t        ctl,
    input  logic             prev_lt,
    input  seg_t             left,
    input  seg_t             right,
    output seg_t             data,
    output cell_flags_t      flags
);

    seg_t data_reg;
    seg_t data_next;
    logic occupied;

    assign occupied = idx < count;
    assign flags.lt = occupied && (data_reg.seq < ctl.seg.seq);
    assign flags.eq = occupied && (data_reg.seq == ctl.seg.seq);
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins_replace && flags.eq)
        begin
            data_next = ctl.seg;
        end
        else if (ctl.ins_shift && !flags.lt)
        begin
            // first cell at or above the new one takes it, the rest move up
            data_next = prev_lt ? ctl.seg : left;
        end
        else if (ctl.pop)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: rtl/tcp_segment_reorder_buffer.sv
`timescale 1ns / 1ps
`include "tcp_segment_reorder_buffer_macros.svh"

// Sorted store of up to DEPTH segment descriptors for one TCP flow, kept in
// a row of cells ordered by ascending sequence number (plain unsigned
// compare). One request is taken per clock cycle while req_stall is low, and
// its response appears in the output register on the next cycle; every cell
// compares and shifts in the same cycle. The request side stalls only while
// a response waits to be taken. The start value written via cfg_wr_data is
// loaded into the next-expected value on every clear (reset sets it to zero);
// writing it has no other effect.
module tcp_segment_reorder_buffer
    import tsrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0]      start_reg;
    logic [31:0]      expected_reg;
    logic [31:0]      expected_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             accept;
    logic             is_clear;
    logic             is_pop;
    logic             is_insert;
    logic             dup;
    logic             full;
    logic             empty;
    logic [DEPTH-1:0] lt_vec;
    logic [DEPTH-1:0] eq_vec;
    logic [CNT_W+4:0] count_ext;
    cell_ctl_t        ctl;
    seg_t             new_seg;
    seg_t             cell_data [DEPTH];
    cell_flags_t      cell_flags [DEPTH];

    assign accept    = req_valid && !req_stall;
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_clear  = req.req_type[1];
    assign is_pop    = !is_clear && (req.req_type == REQ_POP);
    assign is_insert = !is_clear && (req.req_type == REQ_INSERT);
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign dup       = |eq_vec;

    assign new_seg.seq    = req.seq_number;
    assign new_seg.len    = req.payload_length;
    assign new_seg.handle = req.buffer_handle;

    assign ctl.seg         = new_seg;
    assign ctl.ins_replace = accept && is_insert && dup;
    assign ctl.ins_shift   = accept && is_insert && !dup && !full;
    assign ctl.pop         = accept && is_pop && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic prev_lt;
            seg_t left;
            seg_t right;

            if (gi == 0)
            begin : g_head
                assign prev_lt = 1'b0;
                assign left    = new_seg;
            end
            else
            begin : g_body
                assign prev_lt = lt_vec[gi-1];
                assign left    = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right = cell_data[gi];
            end
            else
            begin : g_inner
                assign right = cell_data[gi+1];
            end

            tsrb_cell u_cell (
                .clk     (clk),
                .idx     (CNT_W'(gi)),
                .count   (count_reg),
                .ctl     (ctl),
                .prev_lt (prev_lt),
                .left    (left),
                .right   (right),
                .data    (cell_data[gi]),
                .flags   (cell_flags[gi])
            );

            assign lt_vec[gi] = cell_flags[gi].lt;
            assign eq_vec[gi] = cell_flags[gi].eq;
        end
    endgenerate

    always_comb
    begin
        expected_next = expected_reg;
        count_next    = count_reg;
        rsp_next      = rsp_reg;

        if (accept)
        begin
            rsp_next            = '0;
            rsp_next.out_seq    = '0;
            if (is_clear)
            begin
                count_next      = '0;
                expected_next   = start_reg;
                rsp_next.status = ST_CLEARED;
            end
            else if (is_pop)
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    count_next          = count_reg - 1'b1;
                    expected_next       = expected_reg + {16'd0, cell_data[0].len};
                    rsp_next.status     = ST_POPPED;
                    rsp_next.out_seq    = cell_data[0].seq;
                    rsp_next.out_length = cell_data[0].len;
                    rsp_next.out_handle = cell_data[0].handle;
                end
            end
            else if (dup)
            begin
                rsp_next.status = ST_REPLACED;
            end
            else if (full)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                count_next      = count_reg + 1'b1;
                rsp_next.status = ST_INSERTED;
            end
            rsp_next.next_expected = expected_next;
            rsp_next.entry_count   = count_ext[4:0];
        end
    end

    assign count_ext      = {5'd0, count_next};
    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            expected_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `TSRB_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "held count above depth")
    `TSRB_ASSERT_NEXT(a_pop_count, ctl.pop, count_reg == $past(count_reg) - 1'b1,
        "pop did not shrink the store")
    `TSRB_ASSERT_NEXT(a_clear_state, accept && is_clear,
        count_reg == '0 && expected_reg == $past(start_reg), "clear left state behind")
    `TSRB_ASSERT_NEXT(a_full_drop, accept && is_insert && full && !dup,
        rsp_reg.status == ST_FULL && count_reg == $past(count_reg), "full insert not dropped")
    `TSRB_ASSERT(a_single_op, !(ctl.pop && (ctl.ins_shift || ctl.ins_replace)),
        "cells given more than one operation")

endmodule
